// File: rtl/rtcbcd_pkg.sv
`default_nettype none

package rtcbcd_pkg;

  // register map offsets
  localparam logic [3:0] OffSecUnits  = 4'd0;
  localparam logic [3:0] OffSecTens   = 4'd1;
  localparam logic [3:0] OffMinUnits  = 4'd2;
  localparam logic [3:0] OffMinTens   = 4'd3;
  localparam logic [3:0] OffHourUnits = 4'd4;
  localparam logic [3:0] OffHourTens  = 4'd5;
  localparam logic [3:0] OffDayUnits  = 4'd6;
  localparam logic [3:0] OffDayTens   = 4'd7;
  localparam logic [3:0] OffMonUnits  = 4'd8;
  localparam logic [3:0] OffMonTens   = 4'd9;
  localparam logic [3:0] OffYearUnits = 4'd10;
  localparam logic [3:0] OffYearTens  = 4'd11;
  localparam logic [3:0] OffWeekday   = 4'd12;
  localparam logic [3:0] OffCtrlD     = 4'd13;
  localparam logic [3:0] OffCtrlE     = 4'd14;
  localparam logic [3:0] OffCtrlF     = 4'd15;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // control bit positions
  localparam int HoldBit   = 0;
  localparam int RestBit   = 0;
  localparam int Mode24Bit = 2;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } time_t;

  // quotient by ten through reciprocal multiply, exact for 8-bit values
  function automatic logic [7:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'd205;
    return {3'b000, p[15:11]};
  endfunction

  function automatic logic [7:0] mod10(input logic [7:0] v);
    logic [7:0] q;
    q = div10(v);
    return v - 8'(q * 8'd10);
  endfunction

endpackage

`default_nettype wire

// File: rtl/rtcbcd_digit.sv
`default_nettype none

module rtcbcd_digit (
  input  wire rtcbcd_pkg::time_t tm_i,
  input  wire logic [3:0]        offset_i,
  input  wire logic              mode24_i,
  output logic [7:0]             digit_o
);

  logic [4:0] hour12;
  logic       pm;
  logic [7:0] hour_units;
  logic [7:0] hour_tens;

  always_comb begin
    pm     = (tm_i.hour >= 5'd12);
    hour12 = pm ? (tm_i.hour - 5'd12) : tm_i.hour;
    if (hour12 == 5'd0) begin
      hour12 = 5'd12;
    end
    if (mode24_i) begin
      hour_units = rtcbcd_pkg::mod10({3'b000, tm_i.hour});
      hour_tens  = rtcbcd_pkg::div10({3'b000, tm_i.hour});
    end else begin
      hour_units = rtcbcd_pkg::mod10({3'b000, hour12});
      // pm flag rides in bit 2 of the tens digit
      hour_tens  = rtcbcd_pkg::div10({3'b000, hour12}) | {5'b00000, pm, 2'b00};
    end
  end

  always_comb begin
    unique case (offset_i)
      rtcbcd_pkg::OffSecUnits:  digit_o = rtcbcd_pkg::mod10({2'b00, tm_i.second});
      rtcbcd_pkg::OffSecTens:   digit_o = rtcbcd_pkg::div10({2'b00, tm_i.second});
      rtcbcd_pkg::OffMinUnits:  digit_o = rtcbcd_pkg::mod10({2'b00, tm_i.minute});
      rtcbcd_pkg::OffMinTens:   digit_o = rtcbcd_pkg::div10({2'b00, tm_i.minute});
      rtcbcd_pkg::OffHourUnits: digit_o = hour_units;
      rtcbcd_pkg::OffHourTens:  digit_o = hour_tens;
      rtcbcd_pkg::OffDayUnits:  digit_o = rtcbcd_pkg::mod10({3'b000, tm_i.day});
      rtcbcd_pkg::OffDayTens:   digit_o = rtcbcd_pkg::div10({3'b000, tm_i.day});
      rtcbcd_pkg::OffMonUnits:  digit_o = rtcbcd_pkg::mod10({4'b0000, tm_i.month});
      rtcbcd_pkg::OffMonTens:   digit_o = rtcbcd_pkg::div10({4'b0000, tm_i.month});
      rtcbcd_pkg::OffYearUnits: digit_o = rtcbcd_pkg::mod10(tm_i.year);
      rtcbcd_pkg::OffYearTens:  digit_o = rtcbcd_pkg::div10(tm_i.year);
      rtcbcd_pkg::OffWeekday:   digit_o = {5'b00000, tm_i.weekday};
      default:                  digit_o = 8'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rtc_bcd_register_read_write.sv
// path: an access is captured in the input register, then passes through the
// decode into the result register
// throughput: one access per cycle, limited only by output backpressure
// reset: asynchronous active low, clears valids and control registers d, e, f;
// the held time snapshot is not reset and is valid only after a hold write
`default_nettype none

module rtc_bcd_register_read_write (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // offset[3:0], write_data[11:4], now_second[17:12], now_minute[23:18],
  // now_hour[28:24], now_day[33:29], now_month[37:34], now_year[45:38],
  // now_weekday[48:46], zeros above
  input  wire logic [55:0] s_axis_tdata_i,
  // opcode[0]
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // read_data[7:0]
  output logic [7:0]       m_axis_tdata_o
);

  logic               in_valid_q;
  logic               op_q;
  logic [3:0]         off_q;
  logic [7:0]         wdata_q;
  rtcbcd_pkg::time_t  live_q;

  rtcbcd_pkg::time_t  held_q;
  logic [7:0]         ctrl_d_q, ctrl_e_q, ctrl_f_q;
  logic [7:0]         ctrl_d_d, ctrl_e_d, ctrl_f_d;

  logic               out_valid_q;
  logic [7:0]         out_data_q, out_data_d;

  logic               advance;
  logic               take;
  logic               snap;
  rtcbcd_pkg::time_t  sel_time;
  logic [7:0]         digit;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q           <= s_axis_tuser_i;
      off_q          <= s_axis_tdata_i[3:0];
      wdata_q        <= s_axis_tdata_i[11:4];
      live_q.second  <= s_axis_tdata_i[17:12];
      live_q.minute  <= s_axis_tdata_i[23:18];
      live_q.hour    <= s_axis_tdata_i[28:24];
      live_q.day     <= s_axis_tdata_i[33:29];
      live_q.month   <= s_axis_tdata_i[37:34];
      live_q.year    <= s_axis_tdata_i[45:38];
      live_q.weekday <= s_axis_tdata_i[48:46];
    end
  end

  assign sel_time = ctrl_d_q[rtcbcd_pkg::HoldBit] ? held_q : live_q;

  rtcbcd_digit u_digit (
    .tm_i     (sel_time),
    .offset_i (off_q),
    .mode24_i (ctrl_f_q[rtcbcd_pkg::Mode24Bit]),
    .digit_o  (digit)
  );

  always_comb begin
    ctrl_d_d   = ctrl_d_q;
    ctrl_e_d   = ctrl_e_q;
    ctrl_f_d   = ctrl_f_q;
    snap       = 1'b0;
    out_data_d = 8'd0;
    if (op_q == rtcbcd_pkg::OpRead) begin
      unique case (off_q)
        rtcbcd_pkg::OffCtrlD: out_data_d = ctrl_d_q;
        rtcbcd_pkg::OffCtrlE: out_data_d = ctrl_e_q;
        rtcbcd_pkg::OffCtrlF: out_data_d = ctrl_f_q;
        default:              out_data_d = digit;
      endcase
    end else begin
      unique case (off_q)
        rtcbcd_pkg::OffCtrlD: begin
          ctrl_d_d = wdata_q;
          snap     = wdata_q[rtcbcd_pkg::HoldBit];
        end
        rtcbcd_pkg::OffCtrlE: ctrl_e_d = wdata_q;
        rtcbcd_pkg::OffCtrlF: begin
          // mode bit may only change while rest is set
          if ((wdata_q[rtcbcd_pkg::Mode24Bit] == ctrl_f_q[rtcbcd_pkg::Mode24Bit]) ||
              ctrl_f_q[rtcbcd_pkg::RestBit]) begin
            ctrl_f_d = wdata_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ctrl_d_q    <= 8'd0;
      ctrl_e_q    <= 8'd0;
      ctrl_f_q    <= 8'd0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        ctrl_d_q <= ctrl_d_d;
        ctrl_e_q <= ctrl_e_d;
        ctrl_f_q <= ctrl_f_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_data_q <= out_data_d;
      if (snap) begin
        held_q <= live_q;
      end
    end
  end

endmodule

`default_nettype wire
